@@ hw/rtl/bhmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmf_pkg
// Shared types and constants of the byte histogram mode finder.
// ----------------------------------------------------------------------------
package bhmf_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SYM_W       = 8;
    localparam int OUT_CNT_W   = 16;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [ADDR_W-1:0]      t_addr;

    localparam t_count COUNT_MAX = '1;

    typedef struct packed {
        logic [SYM_W-1:0] byte_value;
        logic             has_byte;
        logic             last_of_set;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0]     mode_symbol;
        logic [OUT_CNT_W-1:0] mode_count;
        logic                 found;
    } t_out_item;

    // request to the histogram memory
    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        logic   clr_en;
        t_addr  addr;
        t_count wdata;
    } t_ram_req;

    typedef enum logic {
        OP_INC,
        OP_MAX
    } t_alu_op;

    typedef struct packed {
        logic   greater;
        t_count sum;
    } t_alu_res;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INC   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_PUSH  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/bhmf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmf_in_if
// Input stream channel: one byte item per transaction.
// ----------------------------------------------------------------------------
interface bhmf_in_if;
    import bhmf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bhmf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmf_out_if
// Result channel: one mode report per transaction.
// ----------------------------------------------------------------------------
interface bhmf_out_if;
    import bhmf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/byte_histogram_mode_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_histogram_mode_finder
// Counts bytes of a data set and reports the most frequent value at its end.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one byte item per transaction (byte_value, has_byte,
//   last_of_set). o_out carries one report per item with last_of_set set:
//   the most frequent byte (lowest on ties), its count saturated to 16 bits,
//   and found, which is low for a set with no counted byte.
// Input handling:
//   a counted byte is read from memory in ST_IDLE and written back in ST_INC
//   after the saturating increment through the shared unit; a marker-only
//   item needs ST_IDLE alone. No new item is taken until ST_IDLE returns.
// End of set:
//   input is held off through the increment (for a byte), the scan of all 256
//   entries over the single memory read port, a drain state for the last
//   compare and the push state loading the output register, valid right after.
// Reset:
//   synchronous, active low; clears every histogram entry at once through
//   the valid bits, so the block is ready the cycle after reset.
// Stall:
//   the report waits in the output register; new bytes are still taken, and
//   only the next end of set waits until the register is free.
// ----------------------------------------------------------------------------
module byte_histogram_mode_finder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bhmf_in_if.sink       i_in,
    bhmf_out_if.source    o_out
);
    import bhmf_pkg::*;

    localparam int WIDE_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

    function automatic logic [OUT_CNT_W-1:0] sat_out(input t_count c);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(c);
        if (w > WIDE_W'(OUT_CNT_MAX)) begin
            return OUT_CNT_MAX;
        end
        return OUT_CNT_W'(w);
    endfunction

    t_state    r_state, n_state;
    t_addr     r_sym;
    logic      r_last;
    t_addr     r_idx;
    t_addr     r_cmp_sym;
    logic      r_cmp_ok;
    t_count    r_best_cnt;
    t_addr     r_best_sym;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_ram_req  ram_req;
    t_count    ram_rdata;
    t_alu_op   alu_op;
    t_alu_res  alu_res;
    logic      in_fire;
    logic      out_free;

    bhmf_count_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    bhmf_alu u_alu (
        .i_op  (alu_op),
        .i_a   (ram_rdata),
        .i_b   (r_best_cnt),
        .o_res (alu_res)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign alu_op      = (r_state == ST_INC) ? OP_INC : OP_MAX;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_comb begin
        ram_req        = '0;
        ram_req.addr   = r_idx;
        ram_req.wdata  = alu_res.sum;
        unique case (r_state)
            ST_IDLE: begin
                ram_req.rd_en = in_fire && i_in.data.has_byte;
                ram_req.addr  = t_addr'(i_in.data.byte_value);
            end
            ST_INC: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = r_sym;
            end
            ST_SCAN: begin
                ram_req.rd_en  = 1'b1;
                ram_req.clr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.data.has_byte) begin
                        n_state = ST_INC;
                    end else if (i_in.data.last_of_set) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_INC:   n_state = r_last ? ST_SCAN : ST_IDLE;
            ST_SCAN:  n_state = (r_idx == t_addr'(TABLE_DEPTH - 1)) ? ST_DRAIN : ST_SCAN;
            ST_DRAIN: n_state = ST_PUSH;
            ST_PUSH:  n_state = out_free ? ST_IDLE : ST_PUSH;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cmp_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_ok <= (r_state == ST_SCAN);
            if (r_state == ST_SCAN) begin
                r_idx <= r_idx + t_addr'(1);
            end
            if (r_state == ST_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sym  <= t_addr'(i_in.data.byte_value);
            r_last <= i_in.data.last_of_set;
        end
        r_cmp_sym <= r_idx;
        // start of scan: clear the running best
        if (r_state != ST_SCAN && n_state == ST_SCAN) begin
            r_best_cnt <= '0;
            r_best_sym <= '0;
        end else if (r_cmp_ok && alu_res.greater) begin
            r_best_cnt <= ram_rdata;
            r_best_sym <= r_cmp_sym;
        end
        if (r_state == ST_PUSH && out_free) begin
            r_out_data.mode_symbol <= SYM_W'(r_best_sym);
            r_out_data.mode_count  <= sat_out(r_best_cnt);
            r_out_data.found       <= (r_best_cnt != '0);
        end
    end

`ifndef SYNTHESIS
    a_push_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("report not loaded when output register free");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_idx == t_addr'(TABLE_DEPTH - 1)) |=>
        (r_state == ST_DRAIN && r_idx == '0 && r_cmp_ok))
        else $error("scan did not end after last entry");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.found) |->
        (o_out.data.mode_count == '0 && o_out.data.mode_symbol == '0))
        else $error("empty set report carries a symbol or count");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.found) |-> (o_out.data.mode_count != '0))
        else $error("found report with zero count");

    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> (!ram_req.clr_en && !ram_req.rd_en && r_state == ST_INC))
        else $error("memory write overlaps read or clear");
`endif

endmodule

@@ hw/rtl/bhmf_count_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmf_count_ram
// Histogram memory with per-entry valid bits; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module bhmf_count_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bhmf_pkg::t_ram_req i_req,
    output bhmf_pkg::t_count   o_rdata
);
    import bhmf_pkg::*;

    t_count                 r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    t_count                 r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_valid[i_req.addr] ? r_mem[i_req.addr] : '0;
        end
    end

    // clear on read drops the entry back to zero for the next set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.addr] <= 1'b1;
        end else if (i_req.clr_en) begin
            r_valid[i_req.addr] <= 1'b0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bhmf_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmf_alu
// Shared counter unit: saturating increment or greater-than compare.
// ----------------------------------------------------------------------------
module bhmf_alu (
    input  bhmf_pkg::t_alu_op  i_op,
    input  bhmf_pkg::t_count   i_a,
    input  bhmf_pkg::t_count   i_b,
    output bhmf_pkg::t_alu_res o_res
);
    import bhmf_pkg::*;

    always_comb begin
        unique case (i_op)
            OP_INC: begin
                o_res.greater = 1'b0;
                o_res.sum     = (i_a == COUNT_MAX) ? i_a : i_a + t_count'(1);
            end
            OP_MAX: begin
                o_res.greater = (i_a > i_b);
                o_res.sum     = i_a;
            end
            default: begin
                o_res.greater = 1'b0;
                o_res.sum     = i_a;
            end
        endcase
    end

endmodule
